[rtl/i2c3w_pkg.sv]
// Shared types and constants for the three-byte I2C write master.
package i2c3w_pkg;

  localparam int unsigned PosW  = 7;
  localparam int unsigned RemW  = 5;
  localparam int unsigned ByteW = 8;

  localparam logic [PosW-1:0] FrameTicks = 7'd88;
  localparam logic [PosW-1:0] StartTicks = 7'd3;
  localparam logic [PosW-1:0] SlotTicks  = 7'd28;
  localparam logic [RemW-1:0] BitsTicks  = 5'd24;
  localparam logic [RemW-1:0] AckHigh    = 5'd25;
  localparam logic [ByteW-1:0] TopBit    = 8'h80;

  localparam logic [ByteW-1:0] AddrCmdRst = 8'd120;
  localparam logic [ByteW-1:0] AddrDatRst = 8'd120;
  localparam logic [ByteW-1:0] CtrlCmdRst = 8'd0;
  localparam logic [ByteW-1:0] CtrlDatRst = 8'd64;

  typedef enum logic [1:0] {
    RegAddrCmd = 2'd0,
    RegAddrDat = 2'd1,
    RegCtrlCmd = 2'd2,
    RegCtrlDat = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    OpTick    = 1'b0,
    OpRequest = 1'b1
  } op_e;

  typedef struct packed {
    logic [ByteW-1:0] address_for_commands;
    logic [ByteW-1:0] address_for_data;
    logic [ByteW-1:0] control_for_commands;
    logic [ByteW-1:0] control_for_data;
  } cfg_t;

  typedef struct packed {
    logic             operation;
    logic [ByteW-1:0] payload_byte;
    logic             is_command;
  } in_item_t;

  typedef struct packed {
    logic clock_line;
    logic data_line;
    logic busy_res;
    logic request_dropped;
    logic frame_done;
  } out_item_t;

endpackage

[rtl/i2c3w_if.sv]
// Valid/ready channel interfaces for request/tick beats and bus-level beats.
interface i2c3w_in_if;
  logic                 valid;
  logic                 ready;
  i2c3w_pkg::in_item_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface i2c3w_out_if;
  logic                 valid;
  logic                 ready;
  i2c3w_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/i2c3w_cfg_regs.sv]
// Configuration register file: address and control bytes for both frame kinds.
module i2c3w_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           write_en,
  input  logic [1:0]                     write_index,
  input  logic [i2c3w_pkg::ByteW-1:0]    write_data,
  output i2c3w_pkg::cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.address_for_commands <= i2c3w_pkg::AddrCmdRst;
      cfg.address_for_data     <= i2c3w_pkg::AddrDatRst;
      cfg.control_for_commands <= i2c3w_pkg::CtrlCmdRst;
      cfg.control_for_data     <= i2c3w_pkg::CtrlDatRst;
    end else if (write_en) begin
      case (i2c3w_pkg::cfg_reg_e'(write_index))
        i2c3w_pkg::RegAddrCmd: cfg.address_for_commands <= write_data;
        i2c3w_pkg::RegAddrDat: cfg.address_for_data     <= write_data;
        i2c3w_pkg::RegCtrlCmd: cfg.control_for_commands <= write_data;
        i2c3w_pkg::RegCtrlDat: cfg.control_for_data     <= write_data;
        default: ;
      endcase
    end
  end

endmodule

[rtl/i2c3w_frame.sv]
// Frame sequencer: tick counter, held transaction and per-tick SCL/SDA levels.
module i2c3w_frame (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  i2c3w_pkg::in_item_t    item,
  input  i2c3w_pkg::cfg_t        cfg,
  output i2c3w_pkg::out_item_t   result
);

  typedef struct packed {
    logic scl;
    logic sda;
  } levels_t;

  logic [i2c3w_pkg::PosW-1:0]  tick_position, tick_position_next;
  logic [i2c3w_pkg::ByteW-1:0] held_payload, held_payload_next;
  logic                        held_kind, held_kind_next;
  logic                        active, active_next;
  logic [i2c3w_pkg::PosW-1:0]  eval_pos;
  levels_t                     lv;

  // Levels on the bus during tick p of the frame.
  function automatic levels_t tick_levels(
    input logic [i2c3w_pkg::PosW-1:0]  p,
    input logic [i2c3w_pkg::ByteW-1:0] addr,
    input logic [i2c3w_pkg::ByteW-1:0] ctrl,
    input logic [i2c3w_pkg::ByteW-1:0] pay
  );
    levels_t                     l;
    logic [i2c3w_pkg::PosW-1:0]  q;
    logic [i2c3w_pkg::PosW-1:0]  rw;
    logic [i2c3w_pkg::RemW-1:0]  r;
    logic [i2c3w_pkg::ByteW-1:0] b;
    logic [7:0]                  prod;
    logic [2:0]                  bidx;
    logic [i2c3w_pkg::RemW-1:0]  ph5;
    logic [1:0]                  phase;
    logic                        val;
    q    = p - i2c3w_pkg::StartTicks;
    rw   = q;
    b    = pay;
    prod = '0;
    bidx = '0;
    ph5  = '0;
    val  = 1'b1;
    l    = '{scl: 1'b1, sda: 1'b1};
    if (q >= (i2c3w_pkg::SlotTicks << 1)) begin
      rw = q - (i2c3w_pkg::SlotTicks << 1);
    end else if (q >= i2c3w_pkg::SlotTicks) begin
      rw = q - i2c3w_pkg::SlotTicks;
      b  = ctrl;
    end else begin
      b  = addr;
    end
    r = rw[i2c3w_pkg::RemW-1:0];
    if (p < i2c3w_pkg::StartTicks) begin
      l.scl = (p < 7'd2);
      l.sda = (p == 7'd0);
    end else if (p >= i2c3w_pkg::FrameTicks - 7'd1) begin
      l.scl = 1'b1;
      l.sda = 1'b0;
    end else if (r < i2c3w_pkg::BitsTicks) begin
      // r/3 for r < 24 via reciprocal: (r * 11) >> 5
      prod  = 8'(r) * 8'd11;
      bidx  = prod[7:5];
      ph5   = r - (5'(bidx) * 5'd3);
      phase = ph5[1:0];
      val   = |((b << bidx) & i2c3w_pkg::TopBit);
      l.scl = (phase == 2'd1);
      l.sda = (phase == 2'd2 && bidx == 3'd7) ? 1'b1 : val;
    end else begin
      // ack clock, answer ignored, then the hold tick
      l.scl = (r == i2c3w_pkg::AckHigh);
      l.sda = 1'b1;
    end
    return l;
  endfunction

  // a dropped request shows the last tick that ran
  assign eval_pos = (item.operation == i2c3w_pkg::OpRequest && tick_position != '0)
                    ? tick_position - 7'd1 : tick_position;

  always_comb begin
    lv = tick_levels(eval_pos,
                     held_kind ? cfg.address_for_commands : cfg.address_for_data,
                     held_kind ? cfg.control_for_commands : cfg.control_for_data,
                     held_payload);
  end

  always_comb begin
    tick_position_next     = tick_position;
    held_payload_next      = held_payload;
    held_kind_next         = held_kind;
    active_next            = active;
    result.clock_line      = 1'b1;
    result.data_line       = 1'b1;
    result.request_dropped = 1'b0;
    result.frame_done      = 1'b0;
    if (item.operation == i2c3w_pkg::OpRequest) begin
      if (active) begin
        result.request_dropped = 1'b1;
        if (tick_position != '0) begin
          result.clock_line = lv.scl;
          result.data_line  = lv.sda;
        end
      end else begin
        held_payload_next  = item.payload_byte;
        held_kind_next     = item.is_command;
        tick_position_next = '0;
        active_next        = 1'b1;
      end
    end else if (active) begin
      result.clock_line = lv.scl;
      result.data_line  = lv.sda;
      if (tick_position >= i2c3w_pkg::FrameTicks - 7'd1) begin
        result.frame_done  = 1'b1;
        active_next        = 1'b0;
        tick_position_next = '0;
      end else begin
        tick_position_next = tick_position + 7'd1;
      end
    end
    result.busy_res = active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_position <= '0;
      held_payload  <= '0;
      held_kind     <= 1'b0;
      active        <= 1'b0;
    end else if (accept) begin
      tick_position <= tick_position_next;
      held_payload  <= held_payload_next;
      held_kind     <= held_kind_next;
      active        <= active_next;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    tick_position <= i2c3w_pkg::FrameTicks - 7'd1)
    else $error("tick position past stop tick");

  a_idle_pos_zero: assert property (@(posedge clk) disable iff (rst)
    !active |-> tick_position == '0)
    else $error("tick position not cleared while idle");

  a_done_ends: assert property (@(posedge clk) disable iff (rst)
    accept && result.frame_done |=> !active)
    else $error("frame still active after stop tick");

  a_drop_keeps: assert property (@(posedge clk) disable iff (rst)
    accept && result.request_dropped |=> active && $stable(tick_position))
    else $error("dropped request disturbed the frame");

endmodule

[rtl/i2c3w_out_reg.sv]
// Result register between the sequencer and the bus-level channel.
module i2c3w_out_reg (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  i2c3w_pkg::out_item_t  result,
  output logic                  space,
  i2c3w_out_if.source           bus
);

  logic                 valid_q;
  i2c3w_pkg::out_item_t data_q;

  // free when empty or being drained this cycle
  assign space       = !valid_q || bus.ready;
  assign bus.valid   = valid_q;
  assign bus.payload = data_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (bus.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_q <= result;
    end
  end

endmodule

[rtl/i2c_three_byte_write_master.sv]
// Top level of the three-byte I2C write master.
//
//  channel  dir  beat contents                               accepted when
//  cmd      in   operation, payload_byte, is_command         cmd.valid & cmd.ready
//  bus      out  clock_line, data_line, busy_res,
//                request_dropped, frame_done                 bus.valid & bus.ready
//  write_*  in   write_index (0..3), write_data (8 bits)     write_en
//
// One beat in, one beat out, one cycle per beat while cmd.ready is high: the sequencer state updates
// at the cmd edge and the levels land in the result register the same edge.
// bus.valid rises in the cycle after cmd acceptance.
// cmd.ready is low only while the result register is full and bus.ready low.
// Synchronous reset: idle, both lines high, defaults in the config registers.
// A full frame is 88 tick beats after the accepted request.
module i2c_three_byte_write_master (
  input  logic                         clk,
  input  logic                         rst,
  i2c3w_in_if.sink                     cmd,
  i2c3w_out_if.source                  bus,
  input  logic                         write_en,
  input  logic [1:0]                   write_index,
  input  logic [i2c3w_pkg::ByteW-1:0]  write_data
);

  i2c3w_pkg::cfg_t      cfg;
  i2c3w_pkg::out_item_t result;
  logic                 space;
  logic                 accept;

  assign cmd.ready = space;
  assign accept    = cmd.valid && space;

  // address/control bytes; the user must write them only between frames, the block does not enforce it
  i2c3w_cfg_regs u_cfg (
    .clk         (clk),
    .rst         (rst),
    .write_en    (write_en),
    .write_index (write_index),
    .write_data  (write_data),
    .cfg         (cfg)
  );

  // tick counter and level generation
  i2c3w_frame u_frame (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (cmd.payload),
    .cfg    (cfg),
    .result (result)
  );

  // result register decouples a stalled sink from the cmd side
  i2c3w_out_reg u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (accept),
    .result (result),
    .space  (space),
    .bus    (bus)
  );

endmodule
